/* rtl/core/dtlv_pkg.sv */
// Shared types and constants for the DER TLV header parser.
package dtlv_pkg;

  // Length bytes accepted in the long form of the length field.
  localparam int MAX_LEN_BYTES = 4;
  localparam int LEN_CNT_W     = $clog2(MAX_LEN_BYTES + 1);

  // Object kinds selected by the object_kind register.
  localparam logic [1:0] KIND_SEQUENCE   = 2'd0;
  localparam logic [1:0] KIND_BIT_STRING = 2'd1;
  localparam logic [1:0] KIND_INTEGER    = 2'd2;

  // Tag bytes for each kind.
  localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
  localparam logic [7:0] TAG_BIT_STRING = 8'h03;
  localparam logic [7:0] TAG_INTEGER    = 8'h02;

  // Configuration register indexes.
  localparam logic REG_OBJECT_KIND = 1'b0;
  localparam logic REG_INT_LIMIT   = 1'b1;

  // Register reset values.
  localparam logic [1:0]  OBJECT_KIND_RESET = KIND_SEQUENCE;
  localparam logic [15:0] INT_LIMIT_RESET   = 16'd16384;

  // Status codes on result transactions.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TAG   = 3'd1;
  localparam logic [2:0] ST_FORM  = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_LONG  = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_TAG       = 4'b0001,
    PH_LEN_FIRST = 4'b0010,
    PH_LEN_MORE  = 4'b0100,
    PH_CONTENT   = 4'b1000
  } phase_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t               phase;
    logic [31:0]          length_accumulator;
    logic [LEN_CNT_W-1:0] length_bytes_left;
    logic [31:0]          content_left;
    logic                 first_content;
  } parse_state_t;

  // One result produced by a byte, with its valid flag.
  typedef struct packed {
    logic        valid;
    logic [7:0]  out_byte;
    logic        is_last;
    logic [31:0] content_length;
    logic [2:0]  status;
  } parse_result_t;

endpackage

/* rtl/core/dtlv_step.sv */
// Combinational parse step: one byte and the current state give the next state and a result.
module dtlv_step
  import dtlv_pkg::*;
(
  input  parse_state_t  state,
  input  logic [7:0]    in_byte,
  input  logic          end_of_buffer,
  input  logic [1:0]    object_kind,
  input  logic [15:0]   integer_length_limit,
  output parse_state_t  state_next,
  output parse_result_t result
);

  logic                 fail;
  logic [2:0]           fail_code;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic                 emit_last;
  logic                 length_done;
  logic [7:0]           want_tag;
  logic                 kind_valid;
  logic [6:0]           len_count;
  logic [LEN_CNT_W-1:0] left_dec;
  logic                 strip;
  logic                 content_last;

  // Expected tag for the configured kind.
  always_comb begin
    kind_valid = 1'b1;
    case (object_kind)
      KIND_SEQUENCE:   want_tag = TAG_SEQUENCE;
      KIND_BIT_STRING: want_tag = TAG_BIT_STRING;
      KIND_INTEGER:    want_tag = TAG_INTEGER;
      default: begin
        want_tag   = 8'h00;
        kind_valid = 1'b0;
      end
    endcase
  end

  assign len_count    = in_byte[6:0];
  assign left_dec     = (state.length_bytes_left != '0) ?
                        state.length_bytes_left - LEN_CNT_W'(1) : '0;
  assign strip        = (object_kind == KIND_INTEGER) && state.first_content &&
                        (in_byte == 8'h00);
  assign content_last = (state.content_left[31:1] == 31'd0);

  // Per-phase decoding, then the shared length check and error handling.
  always_comb begin
    state_next  = state;
    fail        = 1'b0;
    fail_code   = ST_OK;
    emit        = 1'b0;
    emit_byte   = 8'h00;
    emit_last   = 1'b0;
    length_done = 1'b0;

    case (state.phase)
      PH_TAG: begin
        state_next.length_accumulator = 32'd0;
        state_next.length_bytes_left  = '0;
        state_next.content_left       = 32'd0;
        state_next.first_content      = 1'b1;
        if (!kind_valid || in_byte != want_tag) begin
          fail      = 1'b1;
          fail_code = ST_TAG;
        end else if (end_of_buffer) begin
          fail      = 1'b1;
          fail_code = ST_TRUNC;
        end else begin
          state_next.phase = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        if (!in_byte[7]) begin
          state_next.length_accumulator = {24'd0, in_byte};
          length_done = 1'b1;
        end else if (len_count == 7'd0 || len_count > 7'(MAX_LEN_BYTES)) begin
          fail      = 1'b1;
          fail_code = ST_FORM;
        end else begin
          state_next.length_accumulator = 32'd0;
          state_next.length_bytes_left  = len_count[LEN_CNT_W-1:0];
          if (end_of_buffer) begin
            fail      = 1'b1;
            fail_code = ST_TRUNC;
          end else begin
            state_next.phase = PH_LEN_MORE;
          end
        end
      end
      PH_LEN_MORE: begin
        if (state.length_accumulator[31:24] != 8'd0) begin
          fail      = 1'b1;
          fail_code = ST_LONG;
        end else begin
          state_next.length_accumulator = {state.length_accumulator[23:0], in_byte};
          state_next.length_bytes_left  = left_dec;
          if (left_dec == '0) begin
            length_done = 1'b1;
          end else if (end_of_buffer) begin
            fail      = 1'b1;
            fail_code = ST_TRUNC;
          end
        end
      end
      PH_CONTENT: begin
        state_next.first_content = 1'b0;
        if (strip && content_last) begin
          // A lone zero byte of an integer is still delivered.
          state_next.phase        = PH_TAG;
          state_next.content_left = 32'd0;
          emit      = 1'b1;
          emit_last = 1'b1;
        end else if (!content_last && end_of_buffer) begin
          fail      = 1'b1;
          fail_code = ST_TRUNC;
        end else begin
          if (state.content_left != 32'd0) begin
            state_next.content_left = state.content_left - 32'd1;
          end
          if (!strip) begin
            emit      = 1'b1;
            emit_byte = in_byte;
            emit_last = content_last;
            if (content_last) begin
              state_next.phase = PH_TAG;
            end
          end
        end
      end
      default: begin
        fail      = 1'b1;
        fail_code = ST_FORM;
      end
    endcase

    // The full length is known: check it and enter the content phase.
    if (length_done) begin
      if (state_next.length_accumulator == 32'd0) begin
        fail      = 1'b1;
        fail_code = ST_ZERO;
      end else if (object_kind == KIND_INTEGER &&
                   state_next.length_accumulator > {16'd0, integer_length_limit}) begin
        fail      = 1'b1;
        fail_code = ST_LONG;
      end else if (end_of_buffer) begin
        fail      = 1'b1;
        fail_code = ST_TRUNC;
      end else begin
        state_next.content_left  = state_next.length_accumulator;
        state_next.first_content = 1'b1;
        state_next.phase         = PH_CONTENT;
      end
    end

    // An error returns to tag search and reports a zero byte marked last.
    if (fail) begin
      state_next.phase = PH_TAG;
    end
    result.valid          = fail || emit;
    result.out_byte       = fail ? 8'h00 : emit_byte;
    result.is_last        = fail ? 1'b1 : emit_last;
    result.content_length = state_next.length_accumulator;
    result.status         = fail ? fail_code : ST_OK;
  end

endmodule

/* rtl/core/der_tlv_header_parser.sv */
// Top level of the DER TLV header parser: input register, parse step, result register.
// A byte that yields a result reaches the master side through the input and the result register.
// Throughput: one byte per cycle; the parse step is a single pass between two registers.
// A full output register stalls the input register, which in turn drops s_axis_tready.
// Reset (rst, synchronous) empties both registers, returns to tag search and restores
// object_kind to sequence and integer_length_limit to 16384.
module der_tlv_header_parser
  import dtlv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [39:8] content_length,
                                      // [42:40] status, [47:43] zero
  output logic        m_axis_tlast    // is_last
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_eob;
  logic [1:0]    object_kind;
  logic [15:0]   integer_length_limit;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_result;
  parse_result_t out_result;
  logic          advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      object_kind          <= OBJECT_KIND_RESET;
      integer_length_limit <= INT_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBJECT_KIND: object_kind          <= cfg_data[1:0];
        REG_INT_LIMIT:   integer_length_limit <= cfg_data;
        default:         ;
      endcase
    end
  end

  // The held byte moves on when the result register is free or drains this cycle.
  assign advance       = in_valid && (!out_result.valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eob  <= s_axis_tlast;
    end
  end

  dtlv_step u_step (
    .state                (state),
    .in_byte              (in_byte),
    .end_of_buffer        (in_eob),
    .object_kind          (object_kind),
    .integer_length_limit (integer_length_limit),
    .state_next           (state_next),
    .result               (step_result)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase              <= PH_TAG;
      state.length_accumulator <= 32'd0;
      state.length_bytes_left  <= '0;
      state.content_left       <= 32'd0;
      state.first_content      <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_result.valid <= 1'b0;
    end else if (advance) begin
      out_result.valid <= step_result.valid;
    end else if (m_axis_tready) begin
      out_result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_result.valid) begin
      out_result.out_byte       <= step_result.out_byte;
      out_result.is_last        <= step_result.is_last;
      out_result.content_length <= step_result.content_length;
      out_result.status         <= step_result.status;
    end
  end

  assign m_axis_tvalid = out_result.valid;
  assign m_axis_tlast  = out_result.is_last;
  assign m_axis_tdata  = {5'd0, out_result.status, out_result.content_length,
                          out_result.out_byte};

endmodule

/* tb/tb_der_tlv_header_parser.sv */
// Self-checking testbench for the DER TLV header parser with an internal byte-level predictor.
`timescale 1ns / 100ps

module tb_der_tlv_header_parser
  import dtlv_pkg::*;
();

  localparam int LATENCY     = 2;
  localparam int HOLD_CYCLES = 200;

  // Expected content of one result transaction.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] length;
    logic [2:0]  status;
  } tlv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;  // end_of_buffer
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [7:0] out_byte, [39:8] content_length, [42:40] status
  logic        m_axis_tlast;         // is_last

  // Parser state and register copies used for prediction.
  phase_t      prs_phase;
  logic [31:0] len_acc;
  logic [7:0]  len_left;
  logic [31:0] body_left;
  logic        body_first;
  logic [1:0]  kind_cfg;
  logic [15:0] int_limit_cfg;

  tlv_result_t pending_tlv_out [$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          tx_gap_pct = 15;
  int          rx_idle_pct = 25;
  logic        hold_req = 1'b0;

  der_tlv_header_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Run limit, far above the slowest correct run.
  initial begin
    #8_000_000;
    $display("[der_tlv_header_parser] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic tlv_result_t make_res(logic [7:0] d, logic l, logic [2:0] st);
    tlv_result_t r;
    r.data   = d;
    r.last   = l;
    r.length = len_acc;
    r.status = st;
    return r;
  endfunction

  // Error results always end the object and send the parser back to tag search.
  function automatic tlv_result_t abort_object(logic [2:0] st);
    prs_phase = PH_TAG;
    return make_res(8'h00, 1'b1, st);
  endfunction

  // The whole length is known: validate it and enter the content phase.
  function automatic bit finish_length(input logic eob, output tlv_result_t res);
    res = '0;
    if (len_acc == 32'd0) begin
      res = abort_object(ST_ZERO);
      return 1'b1;
    end
    if (kind_cfg == KIND_INTEGER && len_acc > {16'd0, int_limit_cfg}) begin
      res = abort_object(ST_LONG);
      return 1'b1;
    end
    if (eob) begin
      res = abort_object(ST_TRUNC);
      return 1'b1;
    end
    body_left  = len_acc;
    body_first = 1'b1;
    prs_phase  = PH_CONTENT;
    return 1'b0;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic eob,
                                    output tlv_result_t res);
    logic [7:0] want;
    logic [6:0] n;
    bit         strip;
    bit         fin;
    res = '0;
    case (prs_phase)
      PH_TAG: begin
        len_acc    = '0;
        len_left   = '0;
        body_left  = '0;
        body_first = 1'b1;
        case (kind_cfg)
          KIND_SEQUENCE:   want = TAG_SEQUENCE;
          KIND_BIT_STRING: want = TAG_BIT_STRING;
          KIND_INTEGER:    want = TAG_INTEGER;
          default: begin
            res = abort_object(ST_TAG);
            return 1'b1;
          end
        endcase
        if (b != want) begin
          res = abort_object(ST_TAG);
          return 1'b1;
        end
        if (eob) begin
          res = abort_object(ST_TRUNC);
          return 1'b1;
        end
        prs_phase = PH_LEN_FIRST;
        return 1'b0;
      end
      PH_LEN_FIRST: begin
        if (!b[7]) begin
          len_acc = {24'd0, b};
          return finish_length(eob, res);
        end
        n = b[6:0];
        if (n == 7'd0 || n > 7'(MAX_LEN_BYTES)) begin
          res = abort_object(ST_FORM);
          return 1'b1;
        end
        len_acc  = '0;
        len_left = {1'b0, n};
        if (eob) begin
          res = abort_object(ST_TRUNC);
          return 1'b1;
        end
        prs_phase = PH_LEN_MORE;
        return 1'b0;
      end
      PH_LEN_MORE: begin
        if (len_acc[31:24] != 8'd0) begin
          res = abort_object(ST_LONG);
          return 1'b1;
        end
        len_acc = {len_acc[23:0], b};
        if (len_left > 0) len_left--;
        if (len_left == 0) return finish_length(eob, res);
        if (eob) begin
          res = abort_object(ST_TRUNC);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_CONTENT: begin
        // Integer mode drops one leading zero byte unless it is the whole content.
        strip      = (kind_cfg == KIND_INTEGER) && body_first && (b == 8'h00);
        fin        = (body_left <= 32'd1);
        body_first = 1'b0;
        if (strip && fin) begin
          prs_phase = PH_TAG;
          body_left = '0;
          res = make_res(8'h00, 1'b1, ST_OK);
          return 1'b1;
        end
        if (!fin && eob) begin
          res = abort_object(ST_TRUNC);
          return 1'b1;
        end
        if (body_left > 0) body_left--;
        if (strip) return 1'b0;
        if (fin) prs_phase = PH_TAG;
        res = make_res(b, fin, ST_OK);
        return 1'b1;
      end
      default: begin
        res = abort_object(ST_FORM);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic logic [7:0] tag_for_kind(logic [1:0] kind);
    case (kind)
      KIND_BIT_STRING: return TAG_BIT_STRING;
      KIND_INTEGER:    return TAG_INTEGER;
      default:         return TAG_SEQUENCE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare every result transaction with the oldest pending expectation.
  always @(posedge clk) begin : check_results
    tlv_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_tlv_out.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_tlv_out.pop_front();
        if (m_axis_tdata[7:0] != want.data)
          report_mismatch("out_byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
        if (m_axis_tlast != want.last)
          report_mismatch("is_last", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tdata[39:8] != want.length)
          report_mismatch("content_length", m_axis_tdata[39:8], want.length);
        if (m_axis_tdata[42:40] != want.status)
          report_mismatch("status", 32'(m_axis_tdata[42:40]), 32'(want.status));
      end
    end
  end

  // Result side: random idling, or a long hold-off when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req      <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transaction, with an optional idle gap in front of it.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    tlv_result_t res;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (parse_byte(b, eob, res)) pending_tlv_out.push_back(res);
    items_sent++;
  endtask

  // Sends the low n bytes of a packed value, most significant first.
  task automatic send_packed(input logic [63:0] bytes, input int n, input bit eob_last);
    int i;
    for (i = n - 1; i >= 0; i--) send_byte(bytes[8*i +: 8], eob_last && i == 0);
  endtask

  // Builds a TLV frame and sends its first count bytes. form < 0 selects the short
  // length form; otherwise form is the length-byte count of the long form.
  task automatic send_tlv(input logic [7:0] tag, input logic [31:0] len, input int form,
                          input bit lead_zero, input int count, input bit eob_last);
    logic [7:0] frame [$];
    int         hdr;
    int         i;
    frame.push_back(tag);
    if (form < 0) begin
      frame.push_back(len[7:0]);
    end else begin
      frame.push_back(8'h80 | 8'(form));
      for (i = form - 1; i >= 0; i--) frame.push_back(8'(len >> (8 * i)));
    end
    hdr = frame.size();
    while (frame.size() < count)
      frame.push_back((lead_zero && frame.size() == hdr) ? 8'h00 : 8'($urandom));
    while (frame.size() > count) void'(frame.pop_back());
    for (i = 0; i < frame.size(); i++) send_byte(frame[i], eob_last && i == frame.size() - 1);
  endtask

  // Stops offering input until every expected result has come and the pipe is empty.
  task automatic wait_results_drained;
    s_axis_tvalid <= 1'b0;
    while (pending_tlv_out.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_OBJECT_KIND) kind_cfg = val[1:0];
    else int_limit_cfg = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed objects with random content; the rest is broken or noise.
  task automatic send_random_object;
    logic [7:0]  tag;
    logic [31:0] len;
    int          form;
    int          hdr;
    int          count;
    int          roll;
    bit          huge;
    bit          eob_last;
    bit          lead_zero;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      return;
    end
    tag  = ($urandom_range(0, 99) < 90) ? tag_for_kind(kind_cfg) : 8'($urandom);
    huge = 1'b0;
    roll = $urandom_range(0, 99);
    if (roll < 5)       len = '0;
    else if (roll < 75) len = $urandom_range(1, 12);
    else if (roll < 92) len = $urandom_range(13, 300);
    else begin
      len  = $urandom | 32'h0000_1000;
      huge = 1'b1;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      form = 0;
    end else if (roll < 8) begin
      form = $urandom_range(MAX_LEN_BYTES + 1, 127);
    end else if (len < 128 && roll < 60) begin
      form = -1;
    end else begin
      // Shortest long form that holds the length, sometimes padded with zero bytes.
      form = (len[31:24] != 0) ? 4 : (len[23:16] != 0) ? 3 : (len[15:8] != 0) ? 2 : 1;
      form = $urandom_range(form, MAX_LEN_BYTES);
    end
    hdr       = (form > 0) ? 2 + form : 2;
    lead_zero = (kind_cfg == KIND_INTEGER) && ($urandom_range(0, 99) < 30);
    if (form == 0 || form > MAX_LEN_BYTES) begin
      count    = 2;
      eob_last = 1'($urandom_range(0, 1));
    end else if (huge || $urandom_range(0, 99) < 10) begin
      // Buffer ends somewhere in the header or the first content bytes.
      count    = $urandom_range(1, hdr + ((len < 6) ? int'(len) : 6));
      eob_last = 1'b1;
    end else begin
      count    = hdr + int'(len);
      eob_last = 1'($urandom_range(0, 1));
    end
    send_tlv(tag, len, form, lead_zero, count, eob_last);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Header forms, errors and buffer ends with the reset configuration (sequence).
  task automatic test_sequence_headers;
    send_packed(64'h30_02_ff_00, 4, 1'b0);  // extremes of the content byte
    send_packed(64'hff, 1, 1'b0);           // wrong tag
    send_packed(64'h30_80, 2, 1'b0);        // indefinite length
    send_packed(64'h30_85, 2, 1'b0);        // more length bytes than allowed
    send_packed(64'h30_00, 2, 1'b0);        // zero length, short form
    send_packed(64'h30_81_00, 3, 1'b0);     // zero length, long form
    send_packed(64'h30, 1, 1'b1);           // buffer ends on the tag
    send_packed(64'h30_82_01, 3, 1'b1);     // buffer ends inside the length
    send_packed(64'h30_05_aa, 3, 1'b1);     // buffer ends inside the content
    send_packed(64'h30_01_7f, 3, 1'b1);     // buffer ends right on the final byte
    wait_results_drained();
  endtask

  // Integer mode: length limit extremes and leading zero handling.
  task automatic test_integer_rules;
    write_reg(REG_OBJECT_KIND, 16'(KIND_INTEGER));
    write_reg(REG_INT_LIMIT, 16'd1);
    send_packed(64'h02_01_00, 3, 1'b0);     // lone zero byte is kept
    send_packed(64'h02_02, 2, 1'b0);        // above the limit
    send_packed(64'h02_01_80, 3, 1'b0);
    wait_results_drained();
    write_reg(REG_INT_LIMIT, 16'hffff);
    send_packed(64'h02_83_01_00_00, 5, 1'b0);  // one above the largest limit
    send_packed(64'h02_03_00_00_34, 5, 1'b0);  // only the first zero is dropped
    send_packed(64'h30, 1, 1'b0);              // sequence tag in integer mode
    wait_results_drained();
  endtask

  // Bit string mode keeps zero bytes; the unused kind rejects every tag.
  task automatic test_other_kinds;
    write_reg(REG_OBJECT_KIND, 16'(KIND_BIT_STRING));
    send_packed(64'h03_01_00, 3, 1'b0);
    send_packed(64'h02, 1, 1'b0);
    wait_results_drained();
    write_reg(REG_OBJECT_KIND, 16'd3);
    send_packed(64'h30_03_02, 3, 1'b0);
    wait_results_drained();
  endtask

  // Result side held off for a long stretch while the input keeps coming.
  task automatic test_output_backpressure;
    write_reg(REG_OBJECT_KIND, 16'(KIND_SEQUENCE));
    tx_gap_pct = 0;
    hold_req <= 1'b1;
    repeat (4) send_tlv(TAG_SEQUENCE, 32'd10, -1, 1'b0, 12, 1'b0);
    wait_results_drained();
    tx_gap_pct = 15;
  endtask

  // Random objects over a series of register settings.
  task automatic test_random_objects;
    logic [1:0] kind_order [8];
    int         p;
    int         target;
    kind_order = '{KIND_SEQUENCE, KIND_INTEGER, KIND_BIT_STRING, KIND_INTEGER,
                   KIND_SEQUENCE, KIND_INTEGER, KIND_BIT_STRING, KIND_INTEGER};
    for (p = 0; p < 8; p++) begin
      wait_results_drained();
      write_reg(REG_OBJECT_KIND, 16'(kind_order[p]));
      case (p)
        0:       write_reg(REG_INT_LIMIT, 16'hffff);
        1:       write_reg(REG_INT_LIMIT, 16'd1);
        default: write_reg(REG_INT_LIMIT, $urandom_range(0, 1) ? 16'($urandom_range(1, 400))
                                                               : 16'($urandom_range(1, 65535)));
      endcase
      // One phase runs with both sides at full rate.
      tx_gap_pct  = (p == 3) ? 0 : 15;
      rx_idle_pct = (p == 3) ? 0 : 25;
      target = items_sent + 210;
      while (items_sent < target) send_random_object();
    end
    tx_gap_pct  = 15;
    rx_idle_pct = 25;
  endtask

  initial begin
    prs_phase     = PH_TAG;
    len_acc       = '0;
    len_left      = '0;
    body_left     = '0;
    body_first    = 1'b1;
    kind_cfg      = OBJECT_KIND_RESET;
    int_limit_cfg = INT_LIMIT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sequence_headers();
    test_integer_rules();
    test_other_kinds();
    test_output_backpressure();
    test_random_objects();

    wait_results_drained();
    if (mismatch_count == 0)
      $display("[der_tlv_header_parser] OK");
    else
      $display("[der_tlv_header_parser] ERROR");
    $finish;
  end

endmodule
